### design/plcs_pkg.sv
package plcs_pkg;

  // Pixel and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 8;

  localparam logic [PIX_W-1:0] MAX_LEVEL = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 8'd3;

  // Divider geometry: dividend 2*dy*dp + den < 2^18, divisor 2*den < 2^9,
  // quotient fits in a pixel
  localparam int REM_W      = 18;
  localparam int DIV_W      = 9;
  localparam int QUOT_W     = PIX_W;
  localparam int BITS_PER_ST = 2;
  localparam int DIV_STAGES = QUOT_W / BITS_PER_ST;

  // Segment stage: offsets of the pixel on its selected segment
  typedef struct packed {
    logic             last;
    logic             err;
    logic [PIX_W-1:0] y0;
    logic [PIX_W-1:0] dy;
    logic [PIX_W-1:0] dp;
    logic [PIX_W-1:0] den;
  } seg_stage_t;

  // Divider stage: partial remainder and quotient so far
  typedef struct packed {
    logic              last;
    logic              err;
    logic [PIX_W-1:0]  y0;
    logic [REM_W-1:0]  rem;
    logic [DIV_W-1:0]  dvs;
    logic [QUOT_W-1:0] quo;
  } div_stage_t;

endpackage

### design/piecewise_linear_contrast_stretch.sv
// Each accepted input beat moves through seven register stages, the first loading on
// accept and the last being the output register. Throughput: one pixel per cycle while
// out_stall does not hold a beat at the output; segment select, 8x8 multiply, four divider
// stages of two quotient bits each, and a final offset add are all registered.
// Reset (rst_n low, synchronous): pipeline valids clear, breakpoints return to
// (0,0) and (255,255). The configuration port is always ready.
module piecewise_linear_contrast_stretch (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plcs_pkg::PIX_W-1:0]     cfg_data,
  // pixel input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [plcs_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                           in_last_in,
  // pixel result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [plcs_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                           out_last_out,
  output logic                           out_config_error
);

  localparam int PW = plcs_pkg::PIX_W;
  localparam int NS = plcs_pkg::DIV_STAGES;

  logic [PW-1:0] in_low_r, in_high_r, out_low_r, out_high_r;

  logic                  pipe_en;
  logic                  seg_vld_r;
  plcs_pkg::seg_stage_t  seg_r, seg_nxt;
  logic [NS:0]           dv_vld_r;
  plcs_pkg::div_stage_t  dv_r   [0:NS];
  plcs_pkg::div_stage_t  dv_nxt [0:NS];
  logic                  out_vld_r;
  logic [PW-1:0]         pix_r, pix_nxt;
  logic                  last_r, err_r;

  // Advance the whole pipe unless a finished beat is held at the output
  assign pipe_en   = !(out_vld_r && out_stall);
  assign in_stall  = !pipe_en;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_low_r   <= '0;
      in_high_r  <= plcs_pkg::MAX_LEVEL;
      out_low_r  <= '0;
      out_high_r <= plcs_pkg::MAX_LEVEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        plcs_pkg::REG_IN_LOW:   in_low_r   <= cfg_data;
        plcs_pkg::REG_IN_HIGH:  in_high_r  <= cfg_data;
        plcs_pkg::REG_OUT_LOW:  out_low_r  <= cfg_data;
        plcs_pkg::REG_OUT_HIGH: out_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: pick the segment and form its offsets
  always_comb begin
    logic [PW-1:0] x0, y0, x1, y1;
    if (in_pixel_in < in_low_r) begin
      x0 = '0;         y0 = '0;
      x1 = in_low_r;   y1 = out_low_r;
    end else if (in_pixel_in > in_high_r) begin
      x0 = in_high_r;  y0 = out_high_r;
      x1 = plcs_pkg::MAX_LEVEL;
      y1 = plcs_pkg::MAX_LEVEL;
    end else begin
      x0 = in_low_r;   y0 = out_low_r;
      x1 = in_high_r;  y1 = out_high_r;
    end
    seg_nxt.last = in_last_in;
    seg_nxt.err  = (in_low_r >= in_high_r) || (out_low_r >= out_high_r);
    seg_nxt.y0   = y0;
    seg_nxt.dy   = y1 - y0;
    seg_nxt.dp   = in_pixel_in - x0;
    seg_nxt.den  = x1 - x0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_vld_r <= 1'b0;
    end else if (pipe_en) begin
      seg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      seg_r <= seg_nxt;
    end
  end

  // Stage 2: multiply and build dividend 2*dy*dp + den over divisor 2*den
  always_comb begin
    logic [2*PW-1:0] prod;
    prod = seg_r.dy * seg_r.dp;
    dv_nxt[0].last = seg_r.last;
    dv_nxt[0].err  = seg_r.err;
    dv_nxt[0].y0   = seg_r.y0;
    dv_nxt[0].rem  = {1'b0, prod, 1'b0} + plcs_pkg::REM_W'(seg_r.den);
    dv_nxt[0].dvs  = {seg_r.den, 1'b0};
    dv_nxt[0].quo  = '0;
  end

  // Divider stages: restore two quotient bits per stage, MSB first
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_div
      localparam int HI = plcs_pkg::QUOT_W - 1 - plcs_pkg::BITS_PER_ST * gi;
      always_comb begin
        logic [plcs_pkg::REM_W-1:0] r, d_hi, d_lo;
        logic [plcs_pkg::QUOT_W-1:0] q;
        r    = dv_r[gi].rem;
        q    = dv_r[gi].quo;
        d_hi = plcs_pkg::REM_W'(dv_r[gi].dvs) << HI;
        d_lo = plcs_pkg::REM_W'(dv_r[gi].dvs) << (HI - 1);
        if (r >= d_hi) begin
          r     = r - d_hi;
          q[HI] = 1'b1;
        end
        if (r >= d_lo) begin
          r       = r - d_lo;
          q[HI-1] = 1'b1;
        end
        dv_nxt[gi+1]      = dv_r[gi];
        dv_nxt[gi+1].rem  = r;
        dv_nxt[gi+1].quo  = q;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else if (pipe_en) begin
      dv_vld_r <= {dv_vld_r[NS-1:0], seg_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i <= NS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
  end

  // Output stage: add the segment base, force zero on a bad curve
  assign pix_nxt = dv_r[NS].err ? '0 : (dv_r[NS].y0 + dv_r[NS].quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= dv_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pix_r  <= pix_nxt;
      last_r <= dv_r[NS].last;
      err_r  <= dv_r[NS].err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pixel_out    = pix_r;
  assign out_last_out     = last_r;
  assign out_config_error = err_r;

endmodule

### dv/piecewise_linear_contrast_stretch_tb.sv
`timescale 1ns / 1ps

module piecewise_linear_contrast_stretch_tb;

  // One pixel beat on the input channel
  typedef struct packed {
    logic [plcs_pkg::PIX_W-1:0] pix;
    logic                       last;
  } pixel_beat_t;

  // One remapped pixel as the result channel should carry it
  typedef struct {
    logic [plcs_pkg::PIX_W-1:0] level;
    logic                       last;
    logic                       err;
  } stretched_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [plcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [plcs_pkg::PIX_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [plcs_pkg::PIX_W-1:0]     in_pixel_in = '0;
  logic                           in_last_in = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [plcs_pkg::PIX_W-1:0]     out_pixel_out;
  logic                           out_last_out;
  logic                           out_config_error;

  // Breakpoints as the block should hold them
  logic [plcs_pkg::PIX_W-1:0] bp_in_low   = 8'd0;
  logic [plcs_pkg::PIX_W-1:0] bp_in_high  = plcs_pkg::MAX_LEVEL;
  logic [plcs_pkg::PIX_W-1:0] bp_out_low  = 8'd0;
  logic [plcs_pkg::PIX_W-1:0] bp_out_high = plcs_pkg::MAX_LEVEL;

  pixel_beat_t pixel_beats_q[$];
  stretched_t  stretched_q[$];

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int tx_gap = 0;
  int rx_wait = 0;
  int errors = 0;
  int beats_queued = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int err_results = 0;
  int last_results = 0;
  int last_long_hold = 0;
  int long_holds = 0;
  int settings = 0;
  int bad_settings = 0;

  piecewise_linear_contrast_stretch u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_in      (in_pixel_in),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_last_out     (out_last_out),
    .out_config_error (out_config_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Map one pixel through the three-segment curve, rounded half up
  function automatic stretched_t stretch_pixel(pixel_beat_t b);
    stretched_t  r;
    int unsigned p, x0, y0, x1, y1;
    int unsigned il, ih, ol, oh, top;
    p   = 32'(b.pix);
    il  = 32'(bp_in_low);
    ih  = 32'(bp_in_high);
    ol  = 32'(bp_out_low);
    oh  = 32'(bp_out_high);
    top = 32'(plcs_pkg::MAX_LEVEL);
    r.last = b.last;
    r.err = 1'b0;
    r.level = '0;
    if (il >= ih || ol >= oh) begin
      r.err = 1'b1;
    end else begin
      if (p < il) begin
        x0 = 0; y0 = 0; x1 = il; y1 = ol;
      end else if (p > ih) begin
        x0 = ih; y0 = oh; x1 = top; y1 = top;
      end else begin
        x0 = il; y0 = ol; x1 = ih; y1 = oh;
      end
      r.level = plcs_pkg::PIX_W'(y0 + (2 * (y1 - y0) * (p - x0) + (x1 - x0)) /
                                 (2 * (x1 - x0)));
    end
    return r;
  endfunction

  // Driver: present pending pixels, hold while stalled, random idle gaps while send_idle is set
  always @(posedge clk) begin : drive_pixels
    pixel_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.pix = in_pixel_in;
        nxt.last = in_last_in;
        stretched_q.push_back(stretch_pixel(nxt));
        beats_sent++;
        tx_gap = send_idle ? $urandom_range(0, 7) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pixel_beats_q.size() > 0) begin
          nxt = pixel_beats_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_in <= nxt.pix;
          in_last_in <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expected pixel
  always @(posedge clk) begin : check_results
    stretched_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stretched_q.size() == 0) begin
          $error("result beat with no pixel pending: pixel_out %0d", out_pixel_out);
          errors++;
        end else begin
          want = stretched_q.pop_front();
          if (out_pixel_out !== want.level) begin
            $error("pixel_out: expected %0d, got %0d", want.level, out_pixel_out);
            errors++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, out_last_out);
            errors++;
          end
          if (out_config_error !== want.err) begin
            $error("config_error: expected %0b, got %0b", want.err, out_config_error);
            errors++;
          end
          err_results += want.err;
          last_results += want.last;
        end
        results_seen++;
        rx_wait = recv_idle ? $urandom_range(0, 7) : 0;
        // hold off for a long stretch while plenty of pixels are still coming
        if (results_seen - last_long_hold >= 180 && pixel_beats_q.size() >= 40) begin
          rx_wait = $urandom_range(60, 100);
          last_long_hold = results_seen;
          long_holds++;
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  // Write one register and mirror it once the beat is taken
  task automatic write_reg(input logic [plcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plcs_pkg::PIX_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      plcs_pkg::REG_IN_LOW:   bp_in_low = val;
      plcs_pkg::REG_IN_HIGH:  bp_in_high = val;
      plcs_pkg::REG_OUT_LOW:  bp_out_low = val;
      plcs_pkg::REG_OUT_HIGH: bp_out_high = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_breakpoints(input int il, input int ih, input int ol, input int oh);
    write_reg(plcs_pkg::REG_IN_LOW, plcs_pkg::PIX_W'(il));
    write_reg(plcs_pkg::REG_IN_HIGH, plcs_pkg::PIX_W'(ih));
    write_reg(plcs_pkg::REG_OUT_LOW, plcs_pkg::PIX_W'(ol));
    write_reg(plcs_pkg::REG_OUT_HIGH, plcs_pkg::PIX_W'(oh));
    settings++;
    if (il >= ih || ol >= oh)
      bad_settings++;
  endtask

  task automatic push_beat(input int pix, input bit last);
    pixel_beat_t b;
    b.pix = plcs_pkg::PIX_W'(pix);
    b.last = last;
    pixel_beats_q.push_back(b);
    beats_queued++;
  endtask

  // Hold the sender until every queued pixel has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_beats_q.size() != 0 || in_valid || stretched_q.size() != 0);
  endtask

  function automatic int near_level(int v);
    int r;
    r = v + $urandom_range(0, 4) - 2;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r;
  endfunction

  // Queue a random image, biased toward the breakpoints and the ends
  task automatic send_image(input int n);
    int pix;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: pix = near_level($urandom_range(0, 1) ? 32'(bp_in_low) : 32'(bp_in_high));
        1: pix = near_level($urandom_range(0, 1) ? 0 : 255);
        default: pix = $urandom_range(0, 255);
      endcase
      push_beat(pix, (i == n - 1) || ($urandom_range(0, 15) == 0));
    end
    wait_drained();
  endtask

  initial begin
    int il, ih, ol, oh, n, phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // identity curve out of reset, both ends and the middle
    @(negedge clk);
    push_beat(0, 0); push_beat(1, 1); push_beat(127, 0);
    push_beat(128, 0); push_beat(254, 1); push_beat(255, 1);
    wait_drained();

    // pixels below, on and above each breakpoint
    set_breakpoints(64, 192, 32, 224);
    @(negedge clk);
    push_beat(0, 0); push_beat(63, 0); push_beat(64, 0);
    push_beat(192, 0); push_beat(193, 0); push_beat(255, 1);
    wait_drained();

    // exact halves must round up
    set_breakpoints(2, 253, 1, 254);
    @(negedge clk);
    push_beat(1, 0); push_beat(2, 0); push_beat(253, 0); push_beat(254, 1);
    wait_drained();

    // narrowest middle segments at both ends of the range
    set_breakpoints(0, 1, 0, 255);
    @(negedge clk);
    push_beat(1, 0); push_beat(200, 1);
    wait_drained();
    set_breakpoints(254, 255, 0, 1);
    @(negedge clk);
    push_beat(100, 0); push_beat(255, 1);
    wait_drained();

    // breakpoints not strictly increasing
    set_breakpoints(100, 100, 10, 200);
    @(negedge clk);
    push_beat(100, 1);
    wait_drained();
    set_breakpoints(200, 50, 10, 200);
    @(negedge clk);
    push_beat(255, 0);
    wait_drained();
    set_breakpoints(10, 200, 255, 0);
    @(negedge clk);
    push_beat(0, 1);
    wait_drained();

    // writes past the last register must leave the curve alone
    set_breakpoints(40, 160, 20, 240);
    write_reg(8'd4, 8'd0);
    write_reg(8'hFF, 8'hFF);
    @(negedge clk);
    push_beat(100, 1);
    wait_drained();

    // random breakpoints and images
    phase = 0;
    while (beats_queued < 850) begin
      case ($urandom_range(0, 9))
        0: begin
          il = $urandom_range(0, 255); ih = $urandom_range(0, 255);
          ol = $urandom_range(0, 255); oh = $urandom_range(0, 255);
        end
        1, 2: begin
          il = $urandom_range(0, 1) ? 0 : $urandom_range(0, 254);
          ih = $urandom_range(0, 1) ? 255 : $urandom_range(il + 1, 255);
          ol = $urandom_range(0, 1) ? 0 : $urandom_range(0, 254);
          oh = $urandom_range(0, 1) ? 255 : $urandom_range(ol + 1, 255);
        end
        default: begin
          il = $urandom_range(0, 254); ih = $urandom_range(il + 1, 255);
          ol = $urandom_range(0, 254); oh = $urandom_range(ol + 1, 255);
        end
      endcase
      set_breakpoints(il, ih, ol, oh);
      if ($urandom_range(0, 7) == 0)
        write_reg(plcs_pkg::CFG_IDX_W'($urandom_range(4, 255)),
                  plcs_pkg::PIX_W'($urandom_range(0, 255)));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 100);
      // a long gap-free image lets the receiver hold-off back up the pipe
      if (phase % 5 == 2) begin
        n = 250;
        send_idle = 1'b0;
      end
      // stop close to the planned pixel count
      if (n > 850 - beats_queued)
        n = 850 - beats_queued;
      send_image(n);
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d pixels sent, %0d checked over %0d breakpoint settings (%0d invalid)",
             beats_sent, results_seen, settings, bad_settings);
    $display("%0d flagged errors, %0d last-pixel flags, %0d long receiver hold-offs",
             err_results, last_results, long_holds);
    if (errors == 0)
      $display("piecewise_linear_contrast_stretch_tb: done, clean");
    else
      $display("piecewise_linear_contrast_stretch_tb: done, errors");
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("piecewise_linear_contrast_stretch_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
design/plcs_pkg.sv
design/piecewise_linear_contrast_stretch.sv
dv/piecewise_linear_contrast_stretch_tb.sv
